>>> rtl/event_flag_group_waiters_core_defines.svh
// Assertion macros for the event flag group with its table of blocked waiters.
`ifndef EVENT_FLAG_GROUP_WAITERS_CORE_DEFINES_SVH
`define EVENT_FLAG_GROUP_WAITERS_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on the rising clock edge and muted during reset.
`define EFG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("event flag group check failed");

// Next-cycle implication, sampled on the rising clock edge and muted during reset.
`define EFG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("event flag group check failed");

`else

`define EFG_ASSERT_NOW(label, ante, cons)
`define EFG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/efg_pkg.sv
// Shared types and codes for the event flag group with its table of blocked waiters.
`default_nettype none

package efg_pkg;

	localparam logic [1:0] OP_SET   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_WAIT  = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [2:0] STATUS_OK      = 3'd0;
	localparam logic [2:0] STATUS_ZERO    = 3'd1;
	localparam logic [2:0] STATUS_QUEUED  = 3'd2;
	localparam logic [2:0] STATUS_FULL    = 3'd3;
	localparam logic [2:0] STATUS_ALREADY = 3'd4;

	localparam logic KIND_DONE = 1'b0;
	localparam logic KIND_WAKE = 1'b1;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] bits;
		logic [3:0]  task_id;
		logic        wait_all;
		logic        auto_clear;
	} efg_req_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  woken_task;
		logic [31:0] matched_bits;
		logic [31:0] event_word;
		logic [2:0]  status;
		logic        last;
	} efg_rsp_t;

endpackage

`default_nettype wire

>>> rtl/event_flag_group_waiters_core.sv
// Event flag group: event word, first-in first-out table of blocked waiters, wake sequencer.
// A clear, a read and a zero-mask wait go from IDLE straight to DONE; a set first walks the
// table in WALK and any other wait first scans it in SCAN; a held-back result stalls DONE.
// One item is taken at a time, only in IDLE. The single compare unit visits the waiter table
// one entry per cycle, but waits at a satisfied waiter until the result register is free.
// Reset (arst_n low, asynchronous): event word zero, table empty; table entries keep no value.
`default_nettype none

module event_flag_group_waiters_core #(
	parameter int MAX_WAITERS = 16,
	parameter int FLAG_BITS   = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire efg_pkg::efg_req_t req,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output efg_pkg::efg_rsp_t     rsp
);

	import efg_pkg::*;

	`include "event_flag_group_waiters_core_defines.svh"

	localparam int IDX_W = $clog2(MAX_WAITERS);
	localparam int CNT_W = $clog2(MAX_WAITERS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WAITERS);

	// The sequencer: IDLE takes an item, WALK visits waiters after a set, SCAN looks for a
	// duplicate task and then tries the fast path of a wait, DONE hands out the completion.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                 state_q;
	logic [FLAG_BITS-1:0]   word_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       rd_q;
	logic [CNT_W-1:0]       wr_q;
	logic [FLAG_BITS-1:0]   bits_q;
	logic [3:0]             task_q;
	logic                   all_q;
	logic                   clr_q;
	logic [2:0]             status_q;
	logic [FLAG_BITS-1:0]   matched_q;
	efg_rsp_t               rsp_q;
	logic                   rsp_valid_q;

	// Waiter table, kept in arrival order; entries at and above cnt_q are stale.
	logic [FLAG_BITS-1:0]   tab_mask_q [MAX_WAITERS];
	logic [3:0]             tab_task_q [MAX_WAITERS];
	logic                   tab_all_q  [MAX_WAITERS];
	logic                   tab_clr_q  [MAX_WAITERS];

	logic [IDX_W-1:0]       rd_idx;
	logic [IDX_W-1:0]       wr_idx;
	logic [IDX_W-1:0]       cnt_idx;
	logic [FLAG_BITS-1:0]   req_bits_w;
	logic [FLAG_BITS-1:0]   unit_mask;
	logic                   unit_all;
	logic [FLAG_BITS-1:0]   unit_and;
	logic                   unit_hit;
	logic [FLAG_BITS-1:0]   word_wake;
	logic                   walk_live;
	logic                   out_free;
	logic                   rsp_load;

	assign rd_idx     = rd_q[IDX_W-1:0];
	assign wr_idx     = wr_q[IDX_W-1:0];
	assign cnt_idx    = cnt_q[IDX_W-1:0];
	assign req_bits_w = FLAG_BITS'(req.bits);
	assign walk_live  = (rd_q < cnt_q);

	// The one shared compare unit. During a walk it tests the waiter under the read
	// pointer; during a wait it tests the requester's own mask against the word.
	always_comb begin
		if (state_q == ST_WALK) begin
			unit_mask = tab_mask_q[rd_idx];
			unit_all  = tab_all_q[rd_idx];
		end else begin
			unit_mask = bits_q;
			unit_all  = all_q;
		end
		unit_and = word_q & unit_mask;
		unit_hit = unit_all ? (unit_and == unit_mask) : (|unit_and);
	end

	// Word as it stands after a woken waiter with clear-on-exit takes its bits.
	assign word_wake = tab_clr_q[rd_idx] ? (word_q & ~unit_mask) : word_q;

	// The result register can take a new item when it is empty or being emptied now.
	assign out_free  = !rsp_valid_q || rsp_ready;

	// A wake or a completion enters the result register in this cycle.
	assign rsp_load  = out_free &&
		((state_q == ST_WALK && walk_live && unit_hit) || state_q == ST_DONE);

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Table writes. A walk compacts the waiters that stay by copying each down to the
	// write pointer; a blocked wait is appended at the fill count.
	always_ff @(posedge clk) begin
		if (state_q == ST_WALK && walk_live && !unit_hit) begin
			tab_mask_q[wr_idx] <= tab_mask_q[rd_idx];
			tab_task_q[wr_idx] <= tab_task_q[rd_idx];
			tab_all_q[wr_idx]  <= tab_all_q[rd_idx];
			tab_clr_q[wr_idx]  <= tab_clr_q[rd_idx];
		end else if (state_q == ST_SCAN && !walk_live && !unit_hit && cnt_q != CNT_MAX) begin
			tab_mask_q[cnt_idx] <= bits_q;
			tab_task_q[cnt_idx] <= task_q;
			tab_all_q[cnt_idx]  <= all_q;
			tab_clr_q[cnt_idx]  <= clr_q;
		end
	end

	// Sequencer, event word, fill count and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			word_q      <= '0;
			cnt_q       <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			bits_q      <= '0;
			task_q      <= '0;
			all_q       <= 1'b0;
			clr_q       <= 1'b0;
			status_q    <= STATUS_OK;
			matched_q   <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// A result loaded now keeps valid high; otherwise valid drops once taken.
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						bits_q    <= req_bits_w;
						task_q    <= req.task_id;
						all_q     <= req.wait_all;
						clr_q     <= req.auto_clear;
						rd_q      <= '0;
						wr_q      <= '0;
						matched_q <= '0;
						status_q  <= STATUS_OK;
						case (req.op)
							OP_SET: begin
								word_q  <= word_q | req_bits_w;
								state_q <= ST_WALK;
							end
							OP_CLEAR: begin
								word_q  <= word_q & ~req_bits_w;
								state_q <= ST_DONE;
							end
							OP_WAIT: begin
								if (req_bits_w == '0) begin
									status_q <= STATUS_ZERO;
									state_q  <= ST_DONE;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (walk_live) begin
						if (unit_hit) begin
							// A satisfied waiter waits here until the result register is free,
							// since a later waiter must see the word after this one's clear.
							if (out_free) begin
								rsp_q.kind         <= KIND_WAKE;
								rsp_q.woken_task   <= tab_task_q[rd_idx];
								rsp_q.matched_bits <= 32'(unit_and);
								rsp_q.event_word   <= 32'(word_wake);
								rsp_q.status       <= STATUS_OK;
								rsp_q.last         <= 1'b0;
								word_q             <= word_wake;
								rd_q               <= rd_q + 1'b1;
							end
						end else begin
							rd_q <= rd_q + 1'b1;
							wr_q <= wr_q + 1'b1;
						end
					end else begin
						cnt_q   <= wr_q;
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					if (walk_live) begin
						if (tab_task_q[rd_idx] == task_q) begin
							status_q <= STATUS_ALREADY;
							state_q  <= ST_DONE;
						end else begin
							rd_q <= rd_q + 1'b1;
						end
					end else begin
						if (unit_hit) begin
							matched_q <= unit_and;
							if (clr_q) begin
								word_q <= word_q & ~bits_q;
							end
						end else if (cnt_q == CNT_MAX) begin
							status_q <= STATUS_FULL;
						end else begin
							cnt_q    <= cnt_q + 1'b1;
							status_q <= STATUS_QUEUED;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						rsp_q.kind         <= KIND_DONE;
						rsp_q.woken_task   <= task_q;
						rsp_q.matched_bits <= 32'(matched_q);
						rsp_q.event_word   <= 32'(word_q);
						rsp_q.status       <= status_q;
						rsp_q.last         <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The fill count never passes the table size.
	`EFG_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_MAX)
	// Compaction never writes ahead of the entry being read.
	`EFG_ASSERT_NOW(a_walk_order, state_q == ST_WALK, wr_q <= rd_q)
	// Only the completion of an item closes it, and a completion always closes it.
	`EFG_ASSERT_NOW(a_last_kind, rsp_valid_q, rsp_q.last == (rsp_q.kind == KIND_DONE))
	// An accepted item always takes the sequencer out of the idle state.
	`EFG_ASSERT_NEXT(a_busy_after_take, req_valid && req_ready, state_q != ST_IDLE)

endmodule

`default_nettype wire

>>> tb/event_flag_group_waiters_core_test.sv
// Self-checking testbench for the event flag group core and its table of blocked waiters.
`timescale 1ns / 1ps

module event_flag_group_waiters_core_test;
	import efg_pkg::*;

	localparam int MAX_WAITERS = 16;
	localparam int FLAG_BITS   = 32;
	localparam int RANDOM_ITEMS_PER_PHASE = 108;
	// The slowest correct run is far below this: each item walks at most sixteen
	// entries and gives at most seventeen results, even with the receiver
	// stalling half the time.
	localparam int CYCLE_LIMIT = 600000;
	// Cycles allowed after the last expected result: one full table walk plus margin.
	localparam int DRAIN_CYCLES = MAX_WAITERS + 8;

	// The scoreboard keeps its own copy of the event word and of the waiter table.
	// Every accepted item is applied to that copy at once, and the results that the
	// item must cause are queued in order. Each result the block hands over is then
	// matched against the oldest queued one.
	class flag_group_scoreboard;
		localparam int TABLE_DEPTH = 16;
		// All 32 flag bits are in use, so every bit of an item's bits field counts.
		localparam logic [31:0] WORD_MASK = 32'hFFFF_FFFF;

		logic [31:0] flag_word;
		logic [31:0] waiter_bits  [TABLE_DEPTH];
		logic [3:0]  waiter_id    [TABLE_DEPTH];
		bit          waiter_all   [TABLE_DEPTH];
		bit          waiter_clear [TABLE_DEPTH];
		int          waiter_fill;
		efg_rsp_t    pending_rsp_q [$];

		int mismatches;
		int results_checked;
		int requests_seen;
		int wakes_predicted;
		int waits_blocked;
		int waits_duplicate;
		int waits_zero;
		int waits_full;

		function new();
			flag_word = '0;
			waiter_fill = 0;
			mismatches = 0;
			results_checked = 0;
			requests_seen = 0;
			wakes_predicted = 0;
			waits_blocked = 0;
			waits_duplicate = 0;
			waits_zero = 0;
			waits_full = 0;
		endfunction

		function bit condition_met(logic [31:0] word, logic [31:0] mask, bit all_mode);
			if (all_mode) begin
				return (word & mask) == mask;
			end
			return (word & mask) != '0;
		endfunction

		// The event word carried by a result is the word as it stands when the
		// result is produced, so the push must follow any clearing it reports.
		function void push_rsp(logic kind, logic [3:0] who, logic [31:0] hit,
				logic [2:0] status, logic last);
			efg_rsp_t r;
			r.kind = kind;
			r.woken_task = who;
			r.matched_bits = hit;
			r.event_word = flag_word;
			r.status = status;
			r.last = last;
			pending_rsp_q.push_back(r);
		endfunction

		function void note_request(efg_req_t q);
			logic [31:0] b;
			logic [31:0] m;
			logic [31:0] hit;
			int keep;
			bit dup;
			b = q.bits & WORD_MASK;
			requests_seen++;
			case (q.op)
				OP_SET: begin
					// Waiters are walked oldest first; a clear-on-exit waiter
					// removes its bits before the next one is looked at.
					flag_word = flag_word | b;
					keep = 0;
					for (int i = 0; i < waiter_fill; i++) begin
						m = waiter_bits[i];
						if (condition_met(flag_word, m, waiter_all[i])) begin
							hit = flag_word & m;
							if (waiter_clear[i]) begin
								flag_word = flag_word & ~m;
							end
							push_rsp(KIND_WAKE, waiter_id[i], hit, STATUS_OK, 1'b0);
							wakes_predicted++;
						end else begin
							waiter_bits[keep] = waiter_bits[i];
							waiter_id[keep] = waiter_id[i];
							waiter_all[keep] = waiter_all[i];
							waiter_clear[keep] = waiter_clear[i];
							keep++;
						end
					end
					waiter_fill = keep;
					push_rsp(KIND_DONE, q.task_id, '0, STATUS_OK, 1'b1);
				end
				OP_CLEAR: begin
					flag_word = flag_word & ~b;
					push_rsp(KIND_DONE, q.task_id, '0, STATUS_OK, 1'b1);
				end
				OP_READ: begin
					push_rsp(KIND_DONE, q.task_id, '0, STATUS_OK, 1'b1);
				end
				default: begin
					// A wait: zero mask first, then the duplicate check, then the
					// fast path, and only then the table.
					dup = 1'b0;
					for (int i = 0; i < waiter_fill; i++) begin
						if (waiter_id[i] == q.task_id) begin
							dup = 1'b1;
						end
					end
					if (b == '0) begin
						push_rsp(KIND_DONE, q.task_id, '0, STATUS_ZERO, 1'b1);
						waits_zero++;
					end else if (dup) begin
						push_rsp(KIND_DONE, q.task_id, '0, STATUS_ALREADY, 1'b1);
						waits_duplicate++;
					end else if (condition_met(flag_word, b, q.wait_all)) begin
						hit = flag_word & b;
						if (q.auto_clear) begin
							flag_word = flag_word & ~b;
						end
						push_rsp(KIND_DONE, q.task_id, hit, STATUS_OK, 1'b1);
					end else if (waiter_fill >= TABLE_DEPTH) begin
						push_rsp(KIND_DONE, q.task_id, '0, STATUS_FULL, 1'b1);
						waits_full++;
					end else begin
						waiter_bits[waiter_fill] = b;
						waiter_id[waiter_fill] = q.task_id;
						waiter_all[waiter_fill] = q.wait_all;
						waiter_clear[waiter_fill] = q.auto_clear;
						waiter_fill++;
						push_rsp(KIND_DONE, q.task_id, '0, STATUS_QUEUED, 1'b1);
						waits_blocked++;
					end
				end
			endcase
		endfunction

		function void show_rsp(string tag, efg_rsp_t r);
			$display("    %s kind=%0d task=%0d matched=%h word=%h status=%0d last=%0d",
				tag, r.kind, r.woken_task, r.matched_bits, r.event_word,
				r.status, r.last);
		endfunction

		function void check_result(efg_rsp_t got);
			efg_rsp_t want;
			bit bad;
			results_checked++;
			if (pending_rsp_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] result with nothing outstanding", $realtime);
					show_rsp("got     ", got);
				end
				return;
			end
			want = pending_rsp_q.pop_front();
			bad = (got.kind !== want.kind) || (got.woken_task !== want.woken_task) ||
				(got.matched_bits !== want.matched_bits) ||
				(got.event_word !== want.event_word) ||
				(got.status !== want.status) || (got.last !== want.last);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] result mismatch", $realtime);
					show_rsp("expected", want);
					show_rsp("got     ", got);
				end
			end
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	efg_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	efg_rsp_t rsp;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int cycle_count = 0;

	flag_group_scoreboard sb = new();

	event_flag_group_waiters_core #(
		.MAX_WAITERS(MAX_WAITERS),
		.FLAG_BITS  (FLAG_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding",
				cycle_count, sb.pending_rsp_q.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: sample on the edge, then decide whether to stall the next cycle.
	// Only one assignment to rsp_ready happens per edge.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			sb.check_result(rsp);
		end
		rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	function automatic efg_req_t make_req(logic [1:0] op, logic [31:0] bits,
			logic [3:0] who, logic all_mode, logic clr_mode);
		efg_req_t r;
		r.op = op;
		r.bits = bits;
		r.task_id = who;
		r.wait_all = all_mode;
		r.auto_clear = clr_mode;
		return r;
	endfunction

	// Sparse patterns dominate so that waits often block and later sets wake them;
	// dense and full-width patterns make sure every bit gets exercised both ways.
	function automatic logic [31:0] random_flag_bits();
		logic [31:0] v;
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: v = '0;
			1: v = '1;
			2, 3, 4, 5: v = 32'd1 << $urandom_range(0, 31);
			6, 7: v = (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31)) |
				(32'd1 << $urandom_range(0, 31));
			default: v = $urandom();
		endcase
		return v;
	endfunction

	function automatic efg_req_t random_request();
		logic [1:0] op;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			op = OP_SET;
		end else if (pick < 45) begin
			op = OP_CLEAR;
		end else if (pick < 90) begin
			op = OP_WAIT;
		end else begin
			op = OP_READ;
		end
		return make_req(op, random_flag_bits(), 4'($urandom_range(0, 15)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endfunction

	// Offers one item and returns at the edge where it is taken. Valid stays high
	// from one item to the next unless an idle gap is inserted before it.
	task automatic send_item(efg_req_t item);
		int gap;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			gap = $urandom_range(1, 6);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!req_ready);
		sb.note_request(item);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A wait with a zero mask, a queued ANY waiter, the same task
		// asking again, an ALL waiter with clear-on-exit, a set that wakes neither,
		// then a set that wakes both in order. Flags on set are ignored.
		send_item(make_req(OP_WAIT, 32'h0000_0000, 4'd3, 1'b1, 1'b1));
		send_item(make_req(OP_WAIT, 32'h0000_0001, 4'd1, 1'b0, 1'b0));
		send_item(make_req(OP_WAIT, 32'h0000_0008, 4'd1, 1'b0, 1'b0));
		send_item(make_req(OP_WAIT, 32'h8000_0006, 4'd2, 1'b1, 1'b1));
		send_item(make_req(OP_SET, 32'h8000_0000, 4'd0, 1'b0, 1'b0));
		send_item(make_req(OP_SET, 32'h0000_0007, 4'd15, 1'b1, 1'b1));
		// Fast path with clear-on-exit, then clearing every bit.
		send_item(make_req(OP_WAIT, 32'h0000_0001, 4'd4, 1'b0, 1'b1));
		send_item(make_req(OP_CLEAR, 32'hFFFF_FFFF, 4'd9, 1'b1, 1'b1));
		// Fill the table with all sixteen tasks on disjoint bit pairs, mixing the
		// ALL and ANY modes and clear-on-exit.
		for (int t = 0; t < MAX_WAITERS; t++) begin
			send_item(make_req(OP_WAIT, 32'd3 << (2 * t), 4'(t), 1'(t % 2 == 0),
				1'(t % 3 == 0)));
		end
		// With the table full, a wait from a listed task reports it as already waiting.
		send_item(make_req(OP_WAIT, 32'h0000_0100, 4'd7, 1'b0, 1'b0));
		// One set with every bit wakes the whole table: sixteen wakes and a completion.
		send_item(make_req(OP_SET, 32'hFFFF_FFFF, 4'd12, 1'b0, 1'b1));
		send_item(make_req(OP_READ, 32'h5555_AAAA, 4'd6, 1'b1, 1'b0));

		// Random part, in phases of idling: none, sender idle, receiver stalling, both.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 52;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 52;
				end
				default: begin
					send_idle_pct = 16;
					recv_stall_pct = 16;
				end
			endcase
			repeat (RANDOM_ITEMS_PER_PHASE) send_item(random_request());
		end
		req_valid <= 1'b0;

		while (sb.pending_rsp_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d items and %0d results, %0d of them wakes of blocked waiters.",
			sb.requests_seen, sb.results_checked, sb.wakes_predicted);
		$display("Waits: %0d blocked, %0d duplicate, %0d zero mask, %0d table full.",
			sb.waits_blocked, sb.waits_duplicate, sb.waits_zero, sb.waits_full);
		$display("Mismatches: %0d.", sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
